// ===== rtl/sta_pkg.sv =====
// Package: shared constants and types for the segment table allocator.
package sta_pkg;

   localparam int SEGMENTS_DEF  = 16;
   localparam int ADDR_BITS_DEF = 48;
   localparam int LEN_BITS      = 32;

   typedef enum logic [1:0] {
      OP_ALLOC_ANY = 2'd0,
      OP_ALLOC_AT  = 2'd1,
      OP_FREE      = 2'd2,
      OP_CHECK     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OVERLAP = 3'd1,
      ST_NOSEG   = 3'd2,
      ST_BOUNDS  = 3'd3,
      ST_FULL    = 3'd4,
      ST_ZERO    = 3'd5,
      ST_NOROOM  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_READ  = 3'd1,
      S_SCAN  = 3'd2,
      S_DECIDE = 3'd3,
      S_WRITE = 3'd4,
      S_OUT   = 3'd5
   } state_type;

endpackage

// ===== rtl/sta_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/segment_table_allocate_and_check.sv =====
// Top level: segment table with first-fit allocation, free and access check.
//
// Input channel req_*: one transaction per operation (opcode, address,
// length). Output channel rsp_*: exactly one result per operation (status,
// base, offset). Segment bases and sizes live in one RAM (registered read);
// valid marks sit in flip-flops cleared at reset, so the table is empty
// right after reset and no clearing pass is needed.
//
// Each operation that is not rejected up front is a scan over all SEGMENTS
// entries, one RAM read per cycle. Free, check and allocate-at take one
// pass; allocate-anywhere takes one pass per candidate base, at most
// SEGMENTS+1 passes, then a write state. Throughput is thus set by the
// table scan through the single RAM read port. Allocations rejected for
// zero size, a full table or no room at the requested base skip the scan.
// One operation is in flight at a time.
// The result waits in an output register; while rsp_tready is low the
// block holds it and takes no new request.
module segment_table_allocate_and_check
   import sta_pkg::*;
#(
   parameter int SEGMENTS  = SEGMENTS_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // fields from bit 0: address, length, zero fill to whole bytes
   input  logic [((ADDR_BITS+LEN_BITS+7)/8)*8-1:0] req_tdata,
   // fields: opcode
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // fields from bit 0: status, base_out, offset_out, zero fill
   output logic [((3+ADDR_BITS+LEN_BITS+7)/8)*8-1:0] rsp_tdata
);
   localparam int IW  = $clog2(SEGMENTS);
   localparam int CW  = $clog2(SEGMENTS+1);
   localparam int EW  = ADDR_BITS + LEN_BITS;
   localparam int RDW = ((3+ADDR_BITS+LEN_BITS+7)/8)*8;
   localparam int SW  = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;
   localparam logic [SW-1:0] TOP = SW'({ADDR_BITS{1'b1}});

   state_type state_ff, state_in;
   opcode_type op_ff, op_in;
   logic [ADDR_BITS-1:0] cur_ff, cur_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [SEGMENTS-1:0]  valid_ff, valid_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;   // index whose data arrives
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        hidx_ff, hidx_in;
   logic [ADDR_BITS-1:0] hbase_ff, hbase_in;
   logic [LEN_BITS-1:0]  hsize_ff, hsize_in;
   logic [SW-1:0]        hend_ff, hend_in;       // base+size (one past last)
   logic [CW-1:0]        steps_ff, steps_in;
   logic [2:0]           st_ff, st_in;
   logic [ADDR_BITS-1:0] bout_ff, bout_in;
   logic [LEN_BITS-1:0]  oout_ff, oout_in;
   logic                 wr_en;
   logic [IW-1:0]        slot;
   logic                 full;
   logic [EW-1:0]        rd_data;
   logic [ADDR_BITS-1:0] e_base;
   logic [LEN_BITS-1:0]  e_size;
   logic [SW-1:0]        e_end, q_end;
   logic                 e_hit;

   sta_ram #(.WIDTH(EW), .DEPTH(SEGMENTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data ({len_ff, cur_ff}),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // lowest free slot
   always_comb begin
      slot = '0;
      full = 1'b1;
      for (int i = SEGMENTS-1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            slot = IW'(i);
            full = 1'b0;
         end
      end
   end

   assign e_base = rd_data[ADDR_BITS-1:0];
   assign e_size = rd_data[EW-1:ADDR_BITS];
   assign e_end  = SW'(e_base) + SW'(e_size);
   assign q_end  = SW'(cur_ff) + SW'(len_ff);

   // per-entry match for the current operation
   always_comb begin
      unique case (op_ff)
         OP_FREE:  e_hit = (e_base == cur_ff);
         OP_CHECK: e_hit = (cur_ff >= e_base) && (SW'(cur_ff) < e_end);
         default:  e_hit = (SW'(cur_ff) < e_end) && (q_end > SW'(e_base));
      endcase
      e_hit = e_hit && valid_ff[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      op_ff <= op_in; cur_ff <= cur_in; len_ff <= len_in;
      cnt_ff <= cnt_in; rd_idx_ff <= rd_idx_in; hit_ff <= hit_in;
      hidx_ff <= hidx_in; hbase_ff <= hbase_in; hsize_ff <= hsize_in;
      hend_ff <= hend_in; steps_ff <= steps_in; st_ff <= st_in;
      bout_ff <= bout_in; oout_ff <= oout_in;
   end

   always_comb begin
      state_in = state_ff; op_in = op_ff; cur_in = cur_ff;
      len_in = len_ff; valid_in = valid_ff; cnt_in = cnt_ff;
      rd_idx_in = rd_idx_ff; hit_in = hit_ff; hidx_in = hidx_ff;
      hbase_in = hbase_ff; hsize_in = hsize_ff; hend_in = hend_ff;
      steps_in = steps_ff; st_in = st_ff; bout_in = bout_ff; oout_in = oout_ff;
      wr_en = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in   = opcode_type'(req_tuser);
               cur_in  = (opcode_type'(req_tuser) == OP_ALLOC_ANY) ? '0
                         : req_tdata[ADDR_BITS-1:0];
               len_in  = req_tdata[EW-1:ADDR_BITS];
               bout_in = '0; oout_in = '0; steps_in = '0; cnt_in = '0;
               hit_in  = 1'b0;
               state_in = S_READ;
               unique case (opcode_type'(req_tuser))
                  OP_ALLOC_ANY, OP_ALLOC_AT: begin
                     if (req_tdata[EW-1:ADDR_BITS] == '0) begin
                        st_in = ST_ZERO; state_in = S_OUT;
                     end else if (full) begin
                        st_in = ST_FULL; state_in = S_OUT;
                     end else if (opcode_type'(req_tuser) == OP_ALLOC_AT &&
                        SW'(req_tdata[ADDR_BITS-1:0]) +
                        SW'(req_tdata[EW-1:ADDR_BITS]) > TOP + 1'b1) begin
                        st_in = ST_NOROOM; state_in = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            // issue read of entry 0; data returns next cycle
            rd_idx_in = cnt_ff[IW-1:0];
            cnt_in = cnt_ff + 1'b1;
            hit_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // pick lowest-based hit (free: first index, bases are unique)
            if (e_hit && (!hit_ff || e_base < hbase_ff)) begin
               hit_in = 1'b1; hidx_in = rd_idx_ff; hbase_in = e_base;
               hsize_in = e_size; hend_in = e_end;
            end
            rd_idx_in = cnt_ff[IW-1:0];
            if (rd_idx_ff == IW'(SEGMENTS-1)) begin
               state_in = S_DECIDE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            cnt_in = '0;
            state_in = S_OUT;
            unique case (op_ff)
               OP_FREE: begin
                  if (hit_ff) begin
                     valid_in[hidx_ff] = 1'b0; st_in = ST_OK;
                  end else begin
                     st_in = ST_NOSEG;
                  end
               end
               OP_CHECK: begin
                  if (!hit_ff) begin
                     st_in = ST_NOSEG;
                  end else begin
                     bout_in = hbase_ff;
                     oout_in = LEN_BITS'(cur_ff - hbase_ff);
                     st_in = ({1'b0, LEN_BITS'(cur_ff - hbase_ff)} +
                              {1'b0, len_ff} > {1'b0, hsize_ff})
                             ? ST_BOUNDS : ST_OK;
                  end
               end
               OP_ALLOC_AT: begin
                  if (hit_ff) st_in = ST_OVERLAP;
                  else state_in = S_WRITE;
               end
               default: begin
                  if (!hit_ff) begin
                     if (q_end > TOP + 1'b1) st_in = ST_NOROOM;
                     else state_in = S_WRITE;
                  end else if (hend_ff > TOP || steps_ff == CW'(SEGMENTS)) begin
                     st_in = ST_NOROOM;
                  end else begin
                     cur_in = hend_ff[ADDR_BITS-1:0];
                     steps_in = steps_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_WRITE: begin
            wr_en = 1'b1;
            valid_in[slot] = 1'b1;
            st_in = ST_OK;
            bout_in = cur_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = RDW'({oout_ff, bout_ff, st_ff});

   // a write only ever targets a free entry
   a_wr_free: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[slot]) else $error("write into a valid entry");
   // a request is never taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken during response");
   // an allocation success marks exactly one more entry valid
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> $countones(valid_ff) == $countones($past(valid_ff)) + 1)
      else $error("valid count mismatch after allocation");
endmodule
